[src/hibe_pkg.sv]
// ----------------------------------------------------------------------------
// HTTP body extractor package
// Shared types and constants for the header scanner, item queue and window
// back end.
// ----------------------------------------------------------------------------
package hibe_pkg;

    // result phase codes
    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_SKIP   = 3'd1,
        PH_PASS   = 3'd2,
        PH_DONE   = 3'd3,
        PH_ERROR  = 3'd4
    } t_phase;

    // classification of a queued byte
    typedef enum logic [1:0] {
        KIND_HDR  = 2'd0,
        KIND_END  = 2'd1,
        KIND_BODY = 2'd2,
        KIND_ERR  = 2'd3
    } t_item_kind;

    typedef enum logic [1:0] {
        FP_HEADER = 2'd0,
        FP_BODY   = 2'd1,
        FP_ERROR  = 2'd2
    } t_front_phase;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_DIV  = 2'd1,
        BK_MUL  = 2'd2
    } t_back_state;

    typedef struct packed {
        t_item_kind  kind;
        logic [7:0]  data;
    } t_q_item;

    typedef struct packed {
        logic        split_mode;
        logic [4:0]  partition_count;
        logic [3:0]  target_partition;
    } t_cfg;

    // configuration register indexes
    localparam logic [1:0] CFG_SPLIT_MODE  = 2'd0;
    localparam logic [1:0] CFG_PART_COUNT  = 2'd1;
    localparam logic [1:0] CFG_TARGET_PART = 2'd2;

    localparam int         QUEUE_DEPTH = 4;
    localparam int         NAME_LEN    = 14;
    localparam logic [4:0] NAME_END    = 5'd14;
    localparam logic [4:0] FOUND_POS   = 5'd16;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;

    function automatic logic [7:0] name_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = "C";
            4'd1:    c = "o";
            4'd2:    c = "n";
            4'd3:    c = "t";
            4'd4:    c = "e";
            4'd5:    c = "n";
            4'd6:    c = "t";
            4'd7:    c = "-";
            4'd8:    c = "L";
            4'd9:    c = "e";
            4'd10:   c = "n";
            4'd11:   c = "g";
            4'd12:   c = "t";
            4'd13:   c = "h";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

[src/hibe_front.sv]
// ----------------------------------------------------------------------------
// HTTP body extractor front end
// Accepts response bytes, scans the header for the length field and the
// blank line, and tags each byte for the back end.
// ----------------------------------------------------------------------------
module hibe_front
    import hibe_pkg::*;
#(
    parameter int LENGTH_BITS = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [7:0]             i_data,
    output logic                   o_ready,
    input  logic                   i_q_full,
    output logic                   o_push,
    output t_q_item                o_item,
    output logic [LENGTH_BITS-1:0] o_content_length
);

    t_front_phase           r_phase, n_phase;
    logic [4:0]             r_match, n_match;
    logic                   r_digits, n_digits;
    logic [1:0]             r_line, n_line;
    logic [LENGTH_BITS-1:0] r_len, n_len;

    logic                   w_accept;
    logic                   w_blank_end;
    logic [LENGTH_BITS+3:0] w_scaled;

    assign o_ready          = !i_q_full;
    assign w_accept         = i_valid && o_ready;
    assign o_push           = w_accept;
    assign o_content_length = r_len;

    // len*10 + digit, never exceeds LENGTH_BITS+4 bits
    assign w_scaled = ({4'b0, r_len} << 3) + ({4'b0, r_len} << 1)
                    + (LENGTH_BITS+4)'(i_data - CHAR_ZERO);

    // header scan datapath
    always_comb begin
        n_match  = r_match;
        n_digits = r_digits;
        n_line   = r_line;
        n_len    = r_len;
        w_blank_end = 1'b0;
        if (w_accept && r_phase == FP_HEADER) begin
            if (r_match < NAME_END) begin
                if (i_data == name_char(r_match[3:0])) begin
                    n_match = r_match + 5'd1;
                end else begin
                    n_match = (i_data == name_char(4'd0)) ? 5'd1 : 5'd0;
                end
            end else if (r_match < FOUND_POS) begin
                n_match = r_match + 5'd1;
                if (r_match + 5'd1 == FOUND_POS) begin
                    n_digits = 1'b1;
                end
            end else if (r_digits) begin
                if (i_data >= CHAR_ZERO && i_data <= CHAR_NINE) begin
                    n_len = (w_scaled[LENGTH_BITS+3:LENGTH_BITS] != 4'd0) ?
                            '1 : w_scaled[LENGTH_BITS-1:0];
                end else begin
                    n_digits = 1'b0;
                end
            end
            if (i_data == CHAR_LF) begin
                n_line      = 2'd0;
                w_blank_end = (r_line == 2'd1);
            end else if (r_line < 2'd2) begin
                n_line = r_line + 2'd1;
            end
        end
    end

    // phase next state
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            FP_HEADER: begin
                if (w_blank_end) begin
                    n_phase = (n_len == '0) ? FP_ERROR : FP_BODY;
                end
            end
            FP_BODY:  n_phase = FP_BODY;
            FP_ERROR: n_phase = FP_ERROR;
            default:  n_phase = FP_ERROR;
        endcase
    end

    // item tagging
    always_comb begin
        o_item.data = i_data;
        case (r_phase)
            FP_HEADER: begin
                if (w_blank_end) begin
                    o_item.kind = (n_len == '0) ? KIND_ERR : KIND_END;
                end else begin
                    o_item.kind = KIND_HDR;
                end
            end
            FP_BODY:  o_item.kind = KIND_BODY;
            default:  o_item.kind = KIND_ERR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= FP_HEADER;
            r_match  <= 5'd0;
            r_digits <= 1'b0;
            r_line   <= 2'd0;
            r_len    <= '0;
        end else begin
            r_phase  <= n_phase;
            r_match  <= n_match;
            r_digits <= n_digits;
            r_line   <= n_line;
            r_len    <= n_len;
        end
    end

    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == FP_ERROR |=> r_phase == FP_ERROR)
        else $error("front left error phase");

    a_digits_after_name: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_digits) |-> r_match == FOUND_POS)
        else $error("digit collection started before name and skip");

    a_len_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != FP_HEADER |=> $stable(r_len))
        else $error("length changed after header end");

endmodule

[src/hibe_queue.sv]
// ----------------------------------------------------------------------------
// HTTP body extractor item queue
// Short FIFO of tagged bytes between the front end and the back end.
// ----------------------------------------------------------------------------
module hibe_queue
    import hibe_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_q_item i_item,
    output logic    o_full,
    input  logic    i_pop,
    output logic    o_valid,
    output t_q_item o_item
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_q_item      r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [PW:0]   r_count;

    assign o_full  = (r_count == (PW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + PW'(1);
            end
            r_count <= r_count + (PW+1)'(i_push) - (PW+1)'(i_pop);
        end
    end

endmodule

[src/hibe_back.sv]
// ----------------------------------------------------------------------------
// HTTP body extractor back end
// Works out the image window at header end (in split mode a bit-serial divide,
// then one multiply) and passes the body bytes that fall inside it.
// ----------------------------------------------------------------------------
module hibe_back
    import hibe_pkg::*;
#(
    parameter int LENGTH_BITS = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    input  logic [LENGTH_BITS-1:0] i_content_length,
    input  logic                   i_q_valid,
    input  t_q_item                i_q_item,
    output logic                   o_pop,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic                   o_payload_valid,
    output logic [7:0]             o_payload_byte,
    output t_phase                 o_phase
);

    localparam int CW = $clog2(LENGTH_BITS);

    t_back_state            r_state, n_state;
    t_phase                 r_bphase, n_bphase;
    logic [LENGTH_BITS-1:0] r_body, n_body;
    logic [LENGTH_BITS-1:0] r_written, n_written;
    logic [LENGTH_BITS-1:0] r_size, n_size;
    logic [LENGTH_BITS-1:0] r_offset, n_offset;
    logic [LENGTH_BITS-1:0] r_quo, n_quo;
    logic [4:0]             r_rem, n_rem;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic                   r_out_valid, n_out_valid;
    logic                   r_out_pvalid, n_out_pvalid;
    logic [7:0]             r_out_byte, n_out_byte;
    t_phase                 r_out_phase, n_out_phase;

    logic                   w_pop;
    logic                   w_split_end;
    logic [4:0]             w_divisor;
    logic [5:0]             w_trial;
    logic [LENGTH_BITS+3:0] w_prod;
    logic [LENGTH_BITS-1:0] w_body_inc;
    logic [LENGTH_BITS-1:0] w_written_inc;

    assign w_pop = (r_state == BK_IDLE) && i_q_valid && (!r_out_valid || i_ready);
    assign o_pop = w_pop;
    assign w_split_end = (i_q_item.kind == KIND_END) && i_cfg.split_mode;

    assign w_divisor = (i_cfg.partition_count == 5'd0) ? 5'd1 : i_cfg.partition_count;
    // remainder stays below the divisor, which may be as large as 31
    assign w_trial   = {r_rem, r_quo[LENGTH_BITS-1]};
    assign w_prod    = r_quo * {{LENGTH_BITS{1'b0}}, i_cfg.target_partition};

    assign w_body_inc    = (r_body == '1) ? r_body : r_body + 1'b1;
    assign w_written_inc = (r_written == '1) ? r_written : r_written + 1'b1;

    assign o_valid         = r_out_valid;
    assign o_payload_valid = r_out_pvalid;
    assign o_payload_byte  = r_out_byte;
    assign o_phase         = r_out_phase;

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: if (w_pop && w_split_end) begin
                n_state = BK_DIV;
            end
            BK_DIV: if (r_cnt == CW'(LENGTH_BITS - 1)) begin
                n_state = BK_MUL;
            end
            BK_MUL:  n_state = BK_IDLE;
            default: n_state = BK_IDLE;
        endcase
    end

    // datapath and result register
    always_comb begin
        n_bphase     = r_bphase;
        n_body       = r_body;
        n_written    = r_written;
        n_size       = r_size;
        n_offset     = r_offset;
        n_quo        = r_quo;
        n_rem        = r_rem;
        n_cnt        = r_cnt;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_pvalid = r_out_pvalid;
        n_out_byte   = r_out_byte;
        n_out_phase  = r_out_phase;
        case (r_state)
            BK_IDLE: begin
                if (w_pop) begin
                    n_out_pvalid = 1'b0;
                    n_out_byte   = 8'h00;
                    case (i_q_item.kind)
                        KIND_HDR: begin
                            n_out_valid = 1'b1;
                            n_out_phase = PH_HEADER;
                        end
                        KIND_ERR: begin
                            n_out_valid = 1'b1;
                            n_out_phase = PH_ERROR;
                        end
                        KIND_END: begin
                            n_bphase  = PH_SKIP;
                            n_body    = '0;
                            n_written = '0;
                            if (i_cfg.split_mode) begin
                                n_quo = i_content_length;
                                n_rem = 5'd0;
                                n_cnt = '0;
                            end else begin
                                n_size      = i_content_length;
                                n_offset    = '0;
                                n_out_valid = 1'b1;
                                n_out_phase = PH_SKIP;
                            end
                        end
                        KIND_BODY: begin
                            n_out_valid = 1'b1;
                            case (r_bphase)
                                PH_SKIP: begin
                                    n_body = w_body_inc;
                                    if (r_body >= r_offset) begin
                                        if (r_written < r_size) begin
                                            n_out_pvalid = 1'b1;
                                            n_out_byte   = i_q_item.data;
                                            n_written    = w_written_inc;
                                            n_bphase = (w_written_inc >= r_size) ?
                                                       PH_DONE : PH_PASS;
                                        end else begin
                                            n_bphase = PH_DONE;
                                        end
                                    end
                                end
                                PH_PASS: begin
                                    if (r_written < r_size) begin
                                        n_out_pvalid = 1'b1;
                                        n_out_byte   = i_q_item.data;
                                        n_written    = w_written_inc;
                                        if (w_written_inc >= r_size) begin
                                            n_bphase = PH_DONE;
                                        end
                                    end else begin
                                        n_bphase = PH_DONE;
                                    end
                                end
                                default: n_bphase = PH_DONE;
                            endcase
                            n_out_phase = n_bphase;
                        end
                        default: n_out_valid = r_out_valid && !i_ready;
                    endcase
                end
            end
            BK_DIV: begin
                // restoring divide, one quotient bit per cycle
                if (w_trial >= {1'b0, w_divisor}) begin
                    n_rem = 5'(w_trial - {1'b0, w_divisor});
                    n_quo = {r_quo[LENGTH_BITS-2:0], 1'b1};
                end else begin
                    n_rem = w_trial[4:0];
                    n_quo = {r_quo[LENGTH_BITS-2:0], 1'b0};
                end
                n_cnt = r_cnt + CW'(1);
            end
            BK_MUL: begin
                n_size   = r_quo;
                n_offset = (w_prod[LENGTH_BITS+3:LENGTH_BITS] != 4'd0) ?
                           '1 : w_prod[LENGTH_BITS-1:0];
                n_out_valid  = 1'b1;
                n_out_pvalid = 1'b0;
                n_out_byte   = 8'h00;
                n_out_phase  = PH_SKIP;
            end
            default: n_out_valid = r_out_valid && !i_ready;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_bphase    <= PH_SKIP;
            r_body      <= '0;
            r_written   <= '0;
            r_size      <= '0;
            r_offset    <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bphase    <= n_bphase;
            r_body      <= n_body;
            r_written   <= n_written;
            r_size      <= n_size;
            r_offset    <= n_offset;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo        <= n_quo;
        r_rem        <= n_rem;
        r_out_pvalid <= n_out_pvalid;
        r_out_byte   <= n_out_byte;
        r_out_phase  <= n_out_phase;
    end

    a_written_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_written <= r_size)
        else $error("more bytes passed than the window holds");

    a_payload_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_pvalid |-> r_out_phase == PH_PASS || r_out_phase == PH_DONE)
        else $error("payload byte outside passing phase");

    a_mul_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == BK_MUL |=> r_out_valid && r_out_phase == PH_SKIP)
        else $error("window computation gave no result");

endmodule

[src/http_image_body_extractor.sv]
// ----------------------------------------------------------------------------
// HTTP image body extractor
// Bytes of an HTTP response enter on the s_axis channel (tdata = byte).
// The header is scanned for the first Content-Length value; the blank line
// ends the header. Each input byte gives one result on m_axis: tuser is
// payload_valid, tdata[7:0] the byte (zero when not passed), tdata[10:8]
// the phase after the byte (header, skipping, passing, finished, error).
// Configuration: cfg_index 0 split mode, 1 partition count, 2 target slice;
// write only while no response is in flight.
// The result passes through the item queue and then the output register.
// Throughput is one byte per cycle, except that in split mode the
// header-end byte holds the back end for the bit-serial divide by the
// partition count and then the offset multiply; a four-entry queue keeps
// taking bytes meanwhile. When m_axis stalls the result register holds
// and the queue fills, then s_axis tready drops.
// Reset returns to header scan and restores default configuration; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module http_image_body_extractor
    import hibe_pkg::*;
#(
    parameter int LENGTH_BITS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] payload_byte, [10:8] phase
    output logic        m_axis_tuser,   // [0] payload_valid
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [4:0]  i_cfg_data
);

    t_cfg                   r_cfg;
    logic                   w_push, w_full, w_pop, w_q_valid;
    t_q_item                w_push_item, w_pop_item;
    logic [LENGTH_BITS-1:0] w_content_length;
    logic [7:0]             w_byte;
    t_phase                 w_phase;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.split_mode       <= 1'b0;
            r_cfg.partition_count  <= 5'd1;
            r_cfg.target_partition <= 4'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_SPLIT_MODE:  r_cfg.split_mode       <= i_cfg_data[0];
                CFG_PART_COUNT:  r_cfg.partition_count  <= i_cfg_data;
                CFG_TARGET_PART: r_cfg.target_partition <= i_cfg_data[3:0];
                default:         r_cfg <= r_cfg;
            endcase
        end
    end

    hibe_front #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (s_axis_tvalid),
        .i_data          (s_axis_tdata),
        .o_ready         (s_axis_tready),
        .i_q_full        (w_full),
        .o_push          (w_push),
        .o_item          (w_push_item),
        .o_content_length(w_content_length)
    );

    hibe_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_item (w_push_item),
        .o_full (w_full),
        .i_pop  (w_pop),
        .o_valid(w_q_valid),
        .o_item (w_pop_item)
    );

    hibe_back #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_content_length(w_content_length),
        .i_q_valid       (w_q_valid),
        .i_q_item        (w_pop_item),
        .o_pop           (w_pop),
        .o_valid         (m_axis_tvalid),
        .i_ready         (m_axis_tready),
        .o_payload_valid (m_axis_tuser),
        .o_payload_byte  (w_byte),
        .o_phase         (w_phase)
    );

    assign m_axis_tdata = {5'b0, w_phase, w_byte};

endmodule
